/* hw/rtl/point_density_binner_core_defines.svh */
// ---------------------------------------------------------------------------
// Point density binner assertion macros
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef POINT_DENSITY_BINNER_CORE_DEFINES_SVH
`define POINT_DENSITY_BINNER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PDB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("point density binner check failed");
`define PDB_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) cond |=> prop) \
    else $error("point density binner check failed");
`else
`define PDB_ASSERT(name, prop)
`define PDB_ASSERT_NEXT(name, cond, prop)
`endif

`endif

/* hw/rtl/pdb_pkg.sv */
// ---------------------------------------------------------------------------
// Point density binner package
// Request and response types, register indexes, sequencer states, constants.
// ---------------------------------------------------------------------------
package pdb_pkg;

  localparam int unsigned PDB_MAX_WIDTH  = 256;
  localparam int unsigned PDB_MAX_HEIGHT = 256;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned GRID_SZ_W  = 9;
  localparam int unsigned PPM_W      = 30;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned REJ_W      = 32;
  localparam int unsigned GREY_W     = 8;

  localparam logic [31:0]        X_MIN_RST = 32'd0;
  localparam logic [31:0]        X_MAX_RST = 32'd167772160;
  localparam logic [31:0]        Y_MIN_RST = 32'd0;
  localparam logic [31:0]        Y_MAX_RST = 32'd167772160;
  localparam logic [PPM_W-1:0]   PPM_RST   = 30'd6553600;
  localparam logic [GRID_SZ_W-1:0] GRID_RST = 9'd256;

  localparam logic [CNT_W-1:0]  CNT_MAX = '1;
  localparam logic [REJ_W-1:0]  REJ_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_MIN       = 3'd0,
    CFG_X_MAX       = 3'd1,
    CFG_Y_MIN       = 3'd2,
    CFG_Y_MAX       = 3'd3,
    CFG_PPM         = 3'd4,
    CFG_GRID_WIDTH  = 3'd5,
    CFG_GRID_HEIGHT = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    FUNC_BIN  = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_ADDR,
    ST_MEM,
    ST_DIV,
    ST_FIN
  } pdb_state_e;

  typedef struct packed {
    logic               func;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [7:0]         read_column;
    logic [7:0]         read_image_row;
  } pdb_req_t;

  typedef struct packed {
    logic              in_window;
    logic [GREY_W-1:0] grey_level;
    logic [CNT_W-1:0]  peak_count;
    logic [REJ_W-1:0]  outside_count;
  } pdb_rsp_t;

  // Zero counts as one, anything above the maximum as the maximum.
  function automatic logic [GRID_SZ_W-1:0] limit_size(input logic [GRID_SZ_W-1:0] v,
                                                      input int unsigned maxv);
    logic [GRID_SZ_W-1:0] r;
    if (v == '0) begin
      r = GRID_SZ_W'(1);
    end else if (32'(v) > maxv) begin
      r = GRID_SZ_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/pdb_if.sv */
// ---------------------------------------------------------------------------
// Point density binner channels
// Valid/ready request and response channels with packed payloads.
// ---------------------------------------------------------------------------
interface pdb_req_if import pdb_pkg::*; ();
  logic     valid;
  logic     ready;
  pdb_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pdb_rsp_if import pdb_pkg::*; ();
  logic     valid;
  logic     ready;
  pdb_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/point_density_binner_core.sv */
// ---------------------------------------------------------------------------
// Point density binner core
// Bins Q15.16 points into a grid of saturating 16-bit counts and reads
// pixels back as grey levels scaled to the running peak.
// ---------------------------------------------------------------------------
// Usage:
//   req_i carries one request per handshake: func 0 bins point_x/point_y,
//   func 1 reads the pixel at read_column / read_image_row (row 0 on top).
//   rsp_o returns exactly one response per request, in order, with the
//   peak count and the outside count as they stand after that request.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   no request is in flight.
//   A bin request runs through the window test, the scale multiply and the
//   read-modify-write of the count memory; a point outside the window goes
//   from the window test straight to the response. A read runs through the
//   address step, the count memory read and the 8-step restoring divide
//   for the grey level. One request is in flight at a time; the next one
//   can be taken in the cycle after the response is loaded.
//   After reset a clearing pass writes zero to every count, one entry a
//   cycle, over all 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries (65536
//   by default); req_i.ready stays low meanwhile.
//   The response register holds a result while rsp_o.ready is low; a
//   finished request waits in the sequencer until it can be loaded.
// ---------------------------------------------------------------------------
`include "point_density_binner_core_defines.svh"

module point_density_binner_core
  import pdb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = PDB_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = PDB_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pdb_req_if.sink               req_i,
  pdb_rsp_if.source             rsp_o
);

  localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned AW    = CW + RW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned PROD_W = 32 + PPM_W;

  // configuration
  logic signed [31:0]    x_min_q, x_max_q, y_min_q, y_max_q;
  logic [PPM_W-1:0]      ppm_q;
  logic [GRID_SZ_W-1:0]  gw_q, gh_q;
  logic [GRID_SZ_W-1:0]  w_eff, h_eff;

  // sequencer and datapath
  pdb_state_e            state_q, state_d;
  logic [AW-1:0]         clr_q;
  pdb_req_t              item_q;
  logic                  inside_q, inside_d;
  logic                  rd_ok_q, rd_ok_d;
  logic [31:0]           dx_q, dy_q;
  logic [PROD_W-1:0]     px_q, py_q;
  logic [AW-1:0]         addr_q, addr_d;
  logic [CNT_W-1:0]      peak_q;
  logic [REJ_W-1:0]      rej_q;
  logic [CNT_W-1:0]      rem_q;
  logic [7:0]            nlo_q;
  logic [GREY_W-1:0]     quo_q;
  logic [2:0]            div_cnt_q;

  // count memory
  logic [CNT_W-1:0]      mem [DEPTH];
  logic [CNT_W-1:0]      rdata_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [CNT_W-1:0]      mem_wdata;
  logic                  mem_re;

  // output register
  logic                  rsp_vld_q;
  pdb_rsp_t              rsp_q;
  logic                  rsp_load;

  // combinational helpers
  logic                  win_hit;
  logic [30:0]           ix, iy;
  logic [GRID_SZ_W-1:0]  lim_x, lim_y, colc, rowc, rd_row;
  logic [CNT_W-1:0]      cnt_inc;
  logic [23:0]           num;
  logic [CNT_W:0]        div_t;
  logic                  div_ge;

  assign w_eff = limit_size(gw_q, MAX_WIDTH);
  assign h_eff = limit_size(gh_q, MAX_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q <= X_MIN_RST;
      x_max_q <= X_MAX_RST;
      y_min_q <= Y_MIN_RST;
      y_max_q <= Y_MAX_RST;
      ppm_q   <= PPM_RST;
      gw_q    <= GRID_RST;
      gh_q    <= GRID_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_X_MIN:       x_min_q <= cfg_data_i;
        CFG_X_MAX:       x_max_q <= cfg_data_i;
        CFG_Y_MIN:       y_min_q <= cfg_data_i;
        CFG_Y_MAX:       y_max_q <= cfg_data_i;
        CFG_PPM:         ppm_q   <= cfg_data_i[PPM_W-1:0];
        CFG_GRID_WIDTH:  gw_q    <= cfg_data_i[GRID_SZ_W-1:0];
        CFG_GRID_HEIGHT: gh_q    <= cfg_data_i[GRID_SZ_W-1:0];
        default: ;
      endcase
    end
  end

  // window test and read gating
  assign win_hit = ($signed(item_q.point_x) >= x_min_q) && ($signed(item_q.point_x) <= x_max_q)
                && ($signed(item_q.point_y) >= y_min_q) && ($signed(item_q.point_y) <= y_max_q);
  assign inside_d = (item_q.func == FUNC_BIN) && win_hit;
  assign rd_ok_d  = (item_q.func == FUNC_READ)
                 && ({1'b0, item_q.read_column} < w_eff)
                 && ({1'b0, item_q.read_image_row} < h_eff)
                 && (peak_q != '0);

  // round half up and clamp
  assign ix     = {1'b0, px_q[PROD_W-1:32]} + 31'(px_q[31]);
  assign iy     = {1'b0, py_q[PROD_W-1:32]} + 31'(py_q[31]);
  assign lim_x  = w_eff - GRID_SZ_W'(1);
  assign lim_y  = h_eff - GRID_SZ_W'(1);
  assign colc   = (ix > 31'(lim_x)) ? lim_x : ix[GRID_SZ_W-1:0];
  assign rowc   = (iy > 31'(lim_y)) ? lim_y : iy[GRID_SZ_W-1:0];
  assign rd_row = lim_y - {1'b0, item_q.read_image_row};
  assign addr_d = (item_q.func == FUNC_READ)
                ? {RW'(rd_row), CW'(item_q.read_column)}
                : {RW'(rowc), CW'(colc)};

  assign cnt_inc = (rdata_q == CNT_MAX) ? CNT_MAX : rdata_q + CNT_W'(1);
  assign num     = {rdata_q, 8'd0} - {8'd0, rdata_q};
  assign div_t   = {rem_q, nlo_q[7]};
  assign div_ge  = div_t >= {1'b0, peak_q};

  assign rsp_load = (state_q == ST_FIN) && (!rsp_vld_q || rsp_o.ready);

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = cnt_inc;
    mem_re    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_i.valid) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (item_q.func == FUNC_READ) begin
          state_d = ST_ADDR;
        end else if (win_hit) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_MUL: state_d = ST_ADDR;
      ST_ADDR: begin
        mem_re  = 1'b1;
        state_d = ST_MEM;
      end
      ST_MEM: begin
        if (item_q.func == FUNC_READ) begin
          state_d = ST_DIV;
        end else begin
          mem_we  = 1'b1;
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_cnt_q == '1) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (rsp_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign req_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      peak_q  <= '0;
      rej_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (state_q == ST_CALC && item_q.func == FUNC_BIN && !win_hit && rej_q != REJ_MAX) begin
        rej_q <= rej_q + REJ_W'(1);
      end
      if (state_q == ST_MEM && item_q.func == FUNC_BIN && cnt_inc > peak_q) begin
        peak_q <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) item_q <= req_i.payload;
    if (state_q == ST_CALC) begin
      inside_q <= inside_d;
      rd_ok_q  <= rd_ok_d;
      dx_q     <= item_q.point_x - x_min_q;
      dy_q     <= item_q.point_y - y_min_q;
    end
    if (state_q == ST_MUL) begin
      px_q <= {{PPM_W{1'b0}}, dx_q} * {32'd0, ppm_q};
      py_q <= {{PPM_W{1'b0}}, dy_q} * {32'd0, ppm_q};
    end
    if (state_q == ST_ADDR) addr_q <= addr_d;
    if (state_q == ST_MEM) begin
      rem_q     <= num[23:8];
      nlo_q     <= num[7:0];
      quo_q     <= '0;
      div_cnt_q <= '0;
    end
    if (state_q == ST_DIV) begin
      rem_q     <= div_ge ? CNT_W'(div_t - {1'b0, peak_q}) : div_t[CNT_W-1:0];
      nlo_q     <= {nlo_q[6:0], 1'b0};
      quo_q     <= {quo_q[GREY_W-2:0], div_ge};
      div_cnt_q <= div_cnt_q + 3'd1;
    end
  end

  // count memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rdata_q <= mem[addr_d];
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_q.in_window     <= (item_q.func == FUNC_BIN) && inside_q;
      rsp_q.grey_level    <= ((item_q.func == FUNC_READ) && rd_ok_q) ? quo_q : '0;
      rsp_q.peak_count    <= peak_q;
      rsp_q.outside_count <= rej_q;
    end
  end

  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.payload = rsp_q;

  `PDB_ASSERT_NEXT(a_peak_monotonic, 1'b1, peak_q >= $past(peak_q))
  `PDB_ASSERT_NEXT(a_reject_step, 1'b1, (rej_q == $past(rej_q)) || (rej_q == $past(rej_q) + 32'd1))
  `PDB_ASSERT(a_bin_no_grey, (rsp_vld_q && rsp_q.in_window) |-> (rsp_q.grey_level == '0))
  `PDB_ASSERT(a_no_write_when_idle, (state_q == ST_IDLE) |-> !mem_we)

endmodule

/* tb/sv/pdb_density_monitor.sv */
// ---------------------------------------------------------------------------
// Point density binner monitor
// Watches the register port and both channels, keeps its own copy of the
// count grid, peak and outside count, and compares every response with the
// oldest prediction. Reports the first mismatches and counts all of them.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module pdb_density_monitor
  import pdb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pdb_req_if                    point_req,
  pdb_rsp_if                    pixel_rsp,
  output int                    mismatch_count,
  output int                    awaited_count
);

  localparam int unsigned MISMATCH_SHOWN = 10;
  localparam int unsigned GREY_FULL      = 255;

  logic [31:0]          win_x_lo, win_x_hi, win_y_lo, win_y_hi;
  logic [PPM_W-1:0]     scale_ppm;
  logic [GRID_SZ_W-1:0] cols_set, rows_set;
  logic [CNT_W-1:0]     tally [PDB_MAX_WIDTH*PDB_MAX_HEIGHT];
  logic [CNT_W-1:0]     peak_seen;
  logic [REJ_W-1:0]     rejected_seen;
  pdb_rsp_t             grey_counts_q [$];
  int                   fails;

  initial begin
    foreach (tally[i]) tally[i] = '0;
  end

  function automatic int unsigned used_size(input logic [GRID_SZ_W-1:0] v,
                                            input int unsigned maxv);
    int unsigned n;
    n = 32'(v);
    if (n == 0) n = 1;
    if (n > maxv) n = maxv;
    return n;
  endfunction

  // Round half up, clamp to the last column or row.
  function automatic int unsigned pixel_index(input longint c, input longint lo,
                                              input int unsigned size);
    longint unsigned d, prod, idx;
    d    = c - lo;
    prod = d * scale_ppm;
    idx  = (prod + 64'h8000_0000) >> 32;
    if (idx > 64'(size - 1)) idx = 64'(size - 1);
    return 32'(idx);
  endfunction

  function automatic pdb_rsp_t histogram_step(input pdb_req_t r);
    pdb_rsp_t    o;
    int unsigned w, h, col, row, addr, cnt, g;
    longint      x, y, xl, xh, yl, yh;
    w = used_size(cols_set, PDB_MAX_WIDTH);
    h = used_size(rows_set, PDB_MAX_HEIGHT);
    o = '0;
    if (r.func == FUNC_BIN) begin
      x  = longint'(r.point_x);
      y  = longint'(r.point_y);
      xl = longint'($signed(win_x_lo));
      xh = longint'($signed(win_x_hi));
      yl = longint'($signed(win_y_lo));
      yh = longint'($signed(win_y_hi));
      if (x < xl || x > xh || y < yl || y > yh) begin
        if (rejected_seen != REJ_MAX) rejected_seen++;
      end else begin
        col  = pixel_index(x, xl, w);
        row  = pixel_index(y, yl, h);
        addr = row * PDB_MAX_WIDTH + col;
        if (tally[addr] != CNT_MAX) tally[addr]++;
        if (tally[addr] > peak_seen) peak_seen = tally[addr];
        o.in_window = 1'b1;
      end
    end else if (32'(r.read_column) < w && 32'(r.read_image_row) < h && peak_seen != 0) begin
      row = h - 1 - 32'(r.read_image_row);
      cnt = 32'(tally[row * PDB_MAX_WIDTH + 32'(r.read_column)]);
      g   = (GREY_FULL * cnt) / 32'(peak_seen);
      if (g > GREY_FULL) g = GREY_FULL;
      o.grey_level = GREY_W'(g);
    end
    o.peak_count    = peak_seen;
    o.outside_count = rejected_seen;
    return o;
  endfunction

  always @(posedge clk_i) begin
    pdb_rsp_t want, got;
    if (!rst_ni) begin
      win_x_lo      = X_MIN_RST;
      win_x_hi      = X_MAX_RST;
      win_y_lo      = Y_MIN_RST;
      win_y_hi      = Y_MAX_RST;
      scale_ppm     = PPM_RST;
      cols_set      = GRID_RST;
      rows_set      = GRID_RST;
      peak_seen     = '0;
      rejected_seen = '0;
      fails         = 0;
      grey_counts_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_X_MIN:       win_x_lo  = cfg_data_i;
          CFG_X_MAX:       win_x_hi  = cfg_data_i;
          CFG_Y_MIN:       win_y_lo  = cfg_data_i;
          CFG_Y_MAX:       win_y_hi  = cfg_data_i;
          CFG_PPM:         scale_ppm = cfg_data_i[PPM_W-1:0];
          CFG_GRID_WIDTH:  cols_set  = cfg_data_i[GRID_SZ_W-1:0];
          CFG_GRID_HEIGHT: rows_set  = cfg_data_i[GRID_SZ_W-1:0];
          default: ;
        endcase
      end
      if (pixel_rsp.valid && pixel_rsp.ready) begin
        got = pixel_rsp.payload;
        if (grey_counts_q.size() == 0) begin
          if (fails < MISMATCH_SHOWN) begin
            $display("%0t: response with no request waiting: in_window %0b grey %0d peak %0d outside %0d",
                     $realtime, got.in_window, got.grey_level, got.peak_count,
                     got.outside_count);
          end
          fails++;
        end else begin
          want = grey_counts_q.pop_front();
          if (want.in_window !== got.in_window || want.grey_level !== got.grey_level ||
              want.peak_count !== got.peak_count ||
              want.outside_count !== got.outside_count) begin
            if (fails < MISMATCH_SHOWN) begin
              $display("%0t: response mismatch (want/got): in_window %0b/%0b grey %0d/%0d",
                       $realtime, want.in_window, got.in_window, want.grey_level,
                       got.grey_level);
              $display("    peak %0d/%0d outside %0d/%0d", want.peak_count,
                       got.peak_count, want.outside_count, got.outside_count);
            end
            fails++;
          end
        end
      end
      if (point_req.valid && point_req.ready) begin
        grey_counts_q = {grey_counts_q, histogram_step(point_req.payload)};
      end
    end
    mismatch_count <= fails;
    awaited_count  <= grey_counts_q.size();
  end

endmodule

/* tb/sv/point_density_binner_core_tb.sv */
// ---------------------------------------------------------------------------
// Point density binner core testbench
// Drives bin and read requests through directed edge cases, random phases
// under several window, scale and grid settings, a long response stall and
// a short run stacked on one bin, with random idling on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module point_density_binner_core_tb;
  import pdb_pkg::*;

  localparam int unsigned CLK_PERIOD_NS = 4;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned CORNER_POINTS = 20;
  localparam longint      TIMEOUT_NS    = 12_000_000;
  localparam longint      Q_MIN         = -64'sd2147483648;
  localparam longint      Q_MAX         = 64'sd2147483647;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int                    mismatch_count;
  int                    awaited_count;
  int unsigned           send_gap_pct = 19;
  int unsigned           recv_gap_pct = 52;
  int unsigned           holds_asked  = 0;
  int unsigned           holds_done   = 0;

  longint                aim_x_lo, aim_x_hi, aim_y_lo, aim_y_hi;
  int unsigned           aim_cols, aim_rows;

  pdb_req_if point_req ();
  pdb_rsp_if pixel_rsp ();

  always #(CLK_PERIOD_NS / 2) clk_i = ~clk_i;

  point_density_binner_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (point_req),
    .rsp_o      (pixel_rsp)
  );

  pdb_density_monitor u_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .point_req      (point_req),
    .pixel_rsp      (pixel_rsp),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  function automatic pdb_req_t bin_at(input longint x, input longint y);
    pdb_req_t r;
    r         = '0;
    r.func    = FUNC_BIN;
    r.point_x = 32'(x);
    r.point_y = 32'(y);
    return r;
  endfunction

  function automatic pdb_req_t read_at(input logic [7:0] col, input logic [7:0] img_row);
    pdb_req_t r;
    r                = '0;
    r.func           = FUNC_READ;
    r.read_column    = col;
    r.read_image_row = img_row;
    return r;
  endfunction

  function automatic longint unsigned window_offset(input longint unsigned span);
    longint unsigned rnd;
    rnd = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       return 0;
      1:       return span;
      default: return rnd % (span + 1);
    endcase
  endfunction

  function automatic pdb_req_t random_request();
    pdb_req_t    r;
    int unsigned pick;
    r.func           = FUNC_BIN;
    r.point_x        = $urandom;
    r.point_y        = $urandom;
    r.read_column    = 8'($urandom);
    r.read_image_row = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      r.func = FUNC_READ;
      if (pick < 25) begin
        r.read_column    = 8'($urandom_range(aim_cols - 1));
        r.read_image_row = 8'($urandom_range(aim_rows - 1));
      end
    end else if (pick < 88 && aim_x_hi >= aim_x_lo && aim_y_hi >= aim_y_lo) begin
      r.point_x = 32'(aim_x_lo + window_offset(aim_x_hi - aim_x_lo));
      r.point_y = 32'(aim_y_lo + window_offset(aim_y_hi - aim_y_lo));
    end else if (pick < 94) begin
      case ($urandom_range(3))
        0:       r.point_x = 32'(aim_x_lo - 1);
        1:       r.point_x = 32'(aim_x_hi + 1);
        2:       r.point_y = 32'(aim_y_lo - 1);
        default: r.point_y = 32'(aim_y_hi + 1);
      endcase
    end
    return r;
  endfunction

  task automatic send(input pdb_req_t r);
    while ($urandom_range(99) < send_gap_pct) begin
      point_req.valid <= 1'b0;
      @(posedge clk_i);
    end
    point_req.valid   <= 1'b1;
    point_req.payload <= r;
    do @(posedge clk_i); while (!point_req.ready);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send(random_request());
  endtask

  // Drop valid and wait until every response is back.
  task automatic settle();
    point_req.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic program_window(input longint xl, input longint xh, input longint yl,
                                input longint yh, input logic [PPM_W-1:0] ppm,
                                input logic [GRID_SZ_W-1:0] gw,
                                input logic [GRID_SZ_W-1:0] gh);
    aim_x_lo = $signed(32'(xl));
    aim_x_hi = $signed(32'(xh));
    aim_y_lo = $signed(32'(yl));
    aim_y_hi = $signed(32'(yh));
    aim_cols = (gw == 0) ? 1 : ((gw > PDB_MAX_WIDTH) ? PDB_MAX_WIDTH : gw);
    aim_rows = (gh == 0) ? 1 : ((gh > PDB_MAX_HEIGHT) ? PDB_MAX_HEIGHT : gh);
    write_reg(CFG_X_MIN, 32'(xl));
    write_reg(CFG_X_MAX, 32'(xh));
    write_reg(CFG_Y_MIN, 32'(yl));
    write_reg(CFG_Y_MAX, 32'(yh));
    write_reg(CFG_PPM, 32'(ppm));
    write_reg(CFG_GRID_WIDTH, 32'(gw));
    write_reg(CFG_GRID_HEIGHT, 32'(gh));
    cfg_we_i <= 1'b0;
  endtask

  // Size the window to roughly cover the grid at the chosen scale.
  task automatic random_window();
    logic [GRID_SZ_W-1:0] gw, gh;
    logic [PPM_W-1:0]     ppm;
    longint unsigned      span_x, span_y, rnd_x, rnd_y;
    gw  = GRID_SZ_W'($urandom_range(1) ? $urandom_range(1, 8) : $urandom_range(1, 256));
    gh  = GRID_SZ_W'($urandom_range(1) ? $urandom_range(1, 8) : $urandom_range(1, 256));
    ppm = PPM_W'(($urandom_range(3) == 0) ? $urandom_range(655, 1048576)
                                          : $urandom_range(655, 655360000));
    span_x = ((64'(gw) << 32) / ppm) * $urandom_range(60, 140) / 100;
    span_y = ((64'(gh) << 32) / ppm) * $urandom_range(60, 140) / 100;
    if (span_x > 64'hFFFF_FFFF) span_x = 64'hFFFF_FFFF;
    if (span_y > 64'hFFFF_FFFF) span_y = 64'hFFFF_FFFF;
    rnd_x = {$urandom, $urandom};
    rnd_y = {$urandom, $urandom};
    rnd_x = rnd_x % (64'h1_0000_0000 - span_x);
    rnd_y = rnd_y % (64'h1_0000_0000 - span_y);
    program_window(Q_MIN + longint'(rnd_x), Q_MIN + longint'(rnd_x + span_x),
                   Q_MIN + longint'(rnd_y), Q_MIN + longint'(rnd_y + span_y),
                   ppm, gw, gh);
  endtask

  // Hold ready low for a long stretch when asked, otherwise stall at random.
  initial begin
    pixel_rsp.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_asked) begin
        pixel_rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        holds_done++;
      end else begin
        pixel_rsp.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_X_MIN;
    cfg_data_i        = '0;
    point_req.valid   = 1'b0;
    point_req.payload = '0;
    aim_x_lo          = 0;
    aim_x_hi          = 167772160;
    aim_y_lo          = 0;
    aim_y_hi          = 167772160;
    aim_cols          = PDB_MAX_WIDTH;
    aim_rows          = PDB_MAX_HEIGHT;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: zero peak, origin, far corner clamped
    send(read_at(0, 0));
    send(bin_at(0, 0));
    send(bin_at(167772160, 167772160));
    settle();

    // 4 m by 4 m window, 4 pixels per metre, 16 by 8 grid
    program_window(-131072, 131072, -65536, 196608, 30'd262144, 9'd16, 9'd8);
    send(bin_at(-131072, -65536));
    send(bin_at(131072, 196608));
    send(bin_at(-131073, 0));
    send(bin_at(131073, 0));
    send(bin_at(0, -65537));
    send(bin_at(0, 196609));
    send(bin_at(Q_MIN, Q_MAX));
    send(bin_at(Q_MAX, Q_MIN));
    send(bin_at(-131072 + 8192, -65536 + 8192));
    send(bin_at(-131072 + 8191, -65536 + 8191));
    send(read_at(0, 7));
    send(read_at(1, 6));
    send(read_at(15, 0));
    send(read_at(16, 0));
    send(read_at(0, 8));
    send(read_at(255, 255));
    send(bin_at(0, 0));
    send(read_at(8, 3));

    send_gap_pct = 19;
    recv_gap_pct = 52;
    settle();
    random_window();
    run_random(200);
    settle();
    program_window(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 30'd655360000, 9'd256, 9'd256);
    run_random(50);
    settle();
    random_window();
    run_random(150);

    send_gap_pct = 52;
    recv_gap_pct = 19;
    settle();
    program_window(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 30'd0, 9'd0, 9'd0);
    run_random(50);
    settle();
    random_window();
    run_random(200);
    settle();
    program_window(1, 0, 1, 0, 30'd655360000, 9'd3, 9'd5);
    run_random(40);
    settle();
    program_window(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 30'h3FFF_FFFF, 9'd511, 9'd300);
    run_random(40);
    settle();
    program_window(-6553600, 6553600, -6553600, 6553600, 30'd655, 9'd256, 9'd256);
    run_random(50);
    settle();
    random_window();
    run_random(150);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    settle();
    random_window();
    holds_asked++;
    run_random(250);

    // stack one corner bin
    settle();
    program_window(0, 65536, 0, 65536, 30'd65536, 9'd2, 9'd2);
    repeat (CORNER_POINTS) send(bin_at(0, 0));
    send(bin_at(65536, 65536));
    send(read_at(0, 1));
    send(read_at(1, 0));
    send(read_at(0, 0));
    send(read_at(1, 1));

    settle();
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/pdb_pkg.sv
hw/rtl/pdb_if.sv
hw/rtl/point_density_binner_core.sv
tb/sv/pdb_density_monitor.sv
tb/sv/point_density_binner_core_tb.sv
